// File: rtl/tlp_pkg.sv
// ----------------------------------------------------------------------------
// tlp_pkg
// Shared constants and helpers for the tally line parser: field widths,
// register indexes, the status-line prefix and whitespace classification.
// ----------------------------------------------------------------------------
package tlp_pkg;

   // field and register widths
   localparam int CHANNEL_W  = 10;
   localparam int TIMEOUT_W  = 16;
   localparam int BYTE_W     = 8;
   localparam int TALLY_W    = 2;
   localparam int PREFIX_W   = 4;
   localparam int VPOS_W     = 11;
   localparam int IDLE_W     = 17;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // highest channel number that can select a tally character
   localparam int MAX_CHANNEL = 1023;

   // register indexes (address bit 2)
   localparam logic [0:0] CSR_CHANNEL = 1'b0;
   localparam logic [0:0] CSR_TIMEOUT = 1'b1;

   // register reset values
   localparam logic [CHANNEL_W-1:0] CHANNEL_RESET = CHANNEL_W'(1);
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(5000);

   // request kinds
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   // tally codes
   localparam logic [TALLY_W-1:0] TALLY_OFF     = 2'd0;
   localparam logic [TALLY_W-1:0] TALLY_PROGRAM = 2'd1;
   localparam logic [TALLY_W-1:0] TALLY_PREVIEW = 2'd2;

   // characters
   localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_ONE = 8'h31;
   localparam logic [BYTE_W-1:0] CH_TWO = 8'h32;

   // prefix length and saturation limits
   localparam logic [PREFIX_W-1:0] PREFIX_LEN = 4'd9;
   localparam logic [VPOS_W-1:0]   VPOS_MAX   = {VPOS_W{1'b1}};
   localparam logic [IDLE_W-1:0]   IDLE_MAX   = {IDLE_W{1'b1}};

   // character expected at each position of "TALLY OK "
   function automatic logic [BYTE_W-1:0] prefix_char(input logic [PREFIX_W-1:0] pos);
      logic [BYTE_W-1:0] ch;
      unique case (pos)
         4'd0:    ch = 8'h54; // T
         4'd1:    ch = 8'h41; // A
         4'd2:    ch = 8'h4C; // L
         4'd3:    ch = 8'h4C; // L
         4'd4:    ch = 8'h59; // Y
         4'd5:    ch = 8'h20; // space
         4'd6:    ch = 8'h4F; // O
         4'd7:    ch = 8'h4B; // K
         4'd8:    ch = 8'h20; // space
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // space, tab, vertical tab, form feed
   function automatic logic is_ws(input logic [BYTE_W-1:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
   endfunction

endpackage

// File: rtl/tally_line_parser.sv
// ----------------------------------------------------------------------------
// tally_line_parser
// Parses "TALLY OK <value>" status lines from a byte stream, picks the
// character of the watched channel and keeps the tally state; forces the
// tally off when no byte arrives within the configured timeout.
// ----------------------------------------------------------------------------
//  Channel   Dir   Contents
//  req_*     in    tuser[0] action (0 byte, 1 ms tick), tdata[7:0] rx_byte
//  rsp_*     out   tdata[1:0] tally, tlast line_done
//  csr_*     in    APB: 0x0 channel[9:0], 0x4 timeout_ms[15:0]
//
//  One request per cycle, one response per request. A request is held in
//  the input register; the parse step runs between it and the response
//  register, which drives rsp_tvalid.
//  Reset clears the parser state and loads channel 1 and timeout 5000 ms.
//  A stalled response holds the response register and, once the input
//  register is full too, req_tready drops; nothing is lost in between.
// ----------------------------------------------------------------------------
module tally_line_parser (
   input  logic                             clock,
   input  logic                             reset,
   // request: tuser[0] action; tdata[7:0] rx_byte
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,
   input  logic [0:0]                       req_tuser,
   // response: tdata[1:0] tally, [7:2] zero; tlast line_done
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,
   output logic                             rsp_tlast,
   // configuration
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tlp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tlp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tlp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import tlp_pkg::*;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_PREFIX,
      PH_GAP,
      PH_VALUE,
      PH_IGNORE
   } phase_type;

   // input register
   logic              in_valid_ff;
   logic              in_action_ff;
   logic [BYTE_W-1:0] in_byte_ff;

   // response register
   logic               out_valid_ff;
   logic [TALLY_W-1:0] out_tally_ff;
   logic               out_done_ff;

   // configuration registers
   logic [CHANNEL_W-1:0] channel_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;

   // parser state
   phase_type            phase_ff,        phase_in;
   logic [PREFIX_W-1:0]  prefix_pos_ff,   prefix_pos_in;
   logic [VPOS_W-1:0]    value_pos_ff,    value_pos_in;
   logic [BYTE_W-1:0]    picked_char_ff,  picked_char_in;
   logic                 picked_valid_ff, picked_valid_in;
   logic                 value_seen_ff,   value_seen_in;
   logic [IDLE_W-1:0]    idle_ms_ff,      idle_ms_in;
   logic [TALLY_W-1:0]   tally_ff,        tally_in;
   logic                 done_in;

   logic out_free;
   logic advance;
   logic csr_write;

   // flow control: the parse step fires when the input register moves on
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(8-TALLY_W){1'b0}}, out_tally_ff};
   assign rsp_tlast  = out_done_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[2:2])
         CSR_CHANNEL: csr_prdata = {{(CSR_DATA_W-CHANNEL_W){1'b0}}, channel_ff};
         CSR_TIMEOUT: csr_prdata = {{(CSR_DATA_W-TIMEOUT_W){1'b0}}, timeout_ff};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff <= CHANNEL_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2:2])
            CSR_CHANNEL: channel_ff <= csr_pwdata[CHANNEL_W-1:0];
            CSR_TIMEOUT: timeout_ff <= csr_pwdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // parse step for the item in the input register
   always_comb begin
      logic [IDLE_W-1:0] idle_inc;
      logic [VPOS_W-1:0] vpos;
      logic              chan_ok;
      logic              take;
      logic              prefix_hit;

      phase_in        = phase_ff;
      prefix_pos_in   = prefix_pos_ff;
      value_pos_in    = value_pos_ff;
      picked_char_in  = picked_char_ff;
      picked_valid_in = picked_valid_ff;
      value_seen_in   = value_seen_ff;
      idle_ms_in      = idle_ms_ff;
      tally_in        = tally_ff;
      done_in         = 1'b0;

      idle_inc   = (idle_ms_ff < IDLE_MAX) ? idle_ms_ff + IDLE_W'(1) : idle_ms_ff;
      chan_ok    = (channel_ff != '0) && (32'(channel_ff) <= MAX_CHANNEL);
      vpos       = (phase_ff == PH_GAP) ? '0 : value_pos_ff;
      take       = 1'b0;
      prefix_hit = (prefix_pos_ff < PREFIX_LEN)
                   && (in_byte_ff == prefix_char(prefix_pos_ff));

      if (in_action_ff == ACT_TICK) begin
         // count idle time; on expiry drop the line and force off
         idle_ms_in = idle_inc;
         if (idle_inc > {1'b0, timeout_ff}) begin
            tally_in        = TALLY_OFF;
            phase_in        = PH_LEAD;
            prefix_pos_in   = '0;
            value_pos_in    = '0;
            picked_char_in  = '0;
            picked_valid_in = 1'b0;
            value_seen_in   = 1'b0;
            idle_ms_in      = '0;
            done_in         = 1'b1;
         end
      end else begin
         idle_ms_in = '0;
         if (in_byte_ff == CH_LF) begin
            // end of line: a counting line sets the tally
            if (phase_ff == PH_VALUE && value_seen_ff) begin
               if (picked_valid_ff && picked_char_ff == CH_ONE) begin
                  tally_in = TALLY_PROGRAM;
               end else if (picked_valid_ff && picked_char_ff == CH_TWO) begin
                  tally_in = TALLY_PREVIEW;
               end else begin
                  tally_in = TALLY_OFF;
               end
            end
            phase_in        = PH_LEAD;
            prefix_pos_in   = '0;
            value_pos_in    = '0;
            picked_char_in  = '0;
            picked_valid_in = 1'b0;
            value_seen_in   = 1'b0;
            done_in         = 1'b1;
         end else if (in_byte_ff != CH_CR) begin
            unique case (phase_ff)
               PH_LEAD, PH_PREFIX: begin
                  if (phase_ff == PH_PREFIX || !is_ws(in_byte_ff)) begin
                     if (prefix_hit) begin
                        prefix_pos_in = prefix_pos_ff + PREFIX_W'(1);
                        phase_in = (prefix_pos_ff + PREFIX_W'(1) == PREFIX_LEN)
                                   ? PH_GAP : PH_PREFIX;
                     end else begin
                        phase_in = PH_IGNORE;
                     end
                  end
               end
               PH_GAP: begin
                  if (!is_ws(in_byte_ff)) begin
                     phase_in      = PH_VALUE;
                     value_seen_in = 1'b1;
                     take          = 1'b1;
                  end
               end
               PH_VALUE:  take = 1'b1;
               PH_IGNORE: ;
               default:   ;
            endcase
            // value character: latch the watched position, advance index
            if (take) begin
               if (chan_ok && vpos == VPOS_W'(channel_ff) - VPOS_W'(1)) begin
                  picked_char_in  = in_byte_ff;
                  picked_valid_in = 1'b1;
               end
               value_pos_in = (vpos < VPOS_MAX) ? vpos + VPOS_W'(1) : vpos;
            end
         end
      end
   end

   // input register: load on acceptance, clear when it moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_action_ff <= req_tuser[0];
         in_byte_ff   <= req_tdata;
      end
   end

   // parser state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_LEAD;
         prefix_pos_ff   <= '0;
         value_pos_ff    <= '0;
         picked_char_ff  <= '0;
         picked_valid_ff <= 1'b0;
         value_seen_ff   <= 1'b0;
         idle_ms_ff      <= '0;
         tally_ff        <= TALLY_OFF;
         out_valid_ff    <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff        <= phase_in;
            prefix_pos_ff   <= prefix_pos_in;
            value_pos_ff    <= value_pos_in;
            picked_char_ff  <= picked_char_in;
            picked_valid_ff <= picked_valid_in;
            value_seen_ff   <= value_seen_in;
            idle_ms_ff      <= idle_ms_in;
            tally_ff        <= tally_in;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
      if (advance) begin
         out_tally_ff <= tally_in;
         out_done_ff  <= done_in;
      end
   end

   // checks
   a_tally_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_tally_ff != 2'd3))
      else $error("tally code out of range");

   a_timeout_off: assert property (@(posedge clock) disable iff (reset)
      (advance && in_action_ff == ACT_TICK && done_in)
      |=> (out_valid_ff && out_done_ff && out_tally_ff == TALLY_OFF
           && idle_ms_ff == '0 && phase_ff == PH_LEAD))
      else $error("timeout did not force tally off and drop the line");

   a_line_feed_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && in_action_ff == ACT_BYTE && in_byte_ff == CH_LF)
      |=> (phase_ff == PH_LEAD && prefix_pos_ff == '0 && !picked_valid_ff
           && out_done_ff))
      else $error("line feed did not restart the line");

   a_value_seen_phase: assert property (@(posedge clock) disable iff (reset)
      value_seen_ff |-> (phase_ff == PH_VALUE))
      else $error("value flag set outside value phase");

endmodule
